### hw/rtl/ncd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_pkg
// shared field widths, constants and request/result types of the
// negative cycle detector
// ----------------------------------------------------------------------------
package ncd_pkg;

  localparam int NODE_BITS   = 10;
  localparam int WEIGHT_BITS = 16;
  localparam int CFG_BITS    = 11;
  localparam int START_DIST  = 100000000;

  // one input request: a directed, weighted edge
  typedef struct packed {
    logic [NODE_BITS-1:0]          src_node;
    logic [NODE_BITS-1:0]          dst_node;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic                          last_edge;
  } in_req_t;

  // one result
  typedef struct packed {
    logic negative_cycle;
    logic input_error;
  } out_res_t;

  // edge store entry
  typedef struct packed {
    logic [NODE_BITS-1:0]          src_node;
    logic [NODE_BITS-1:0]          dst_node;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
  } edge_t;

endpackage

### hw/rtl/ncd_edge_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_edge_mem
// edge store: one write port, one registered read port
// ----------------------------------------------------------------------------
module ncd_edge_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  ncd_pkg::edge_t        wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output ncd_pkg::edge_t        rdata_o
);

  ncd_pkg::edge_t mem_q [DEPTH];
  ncd_pkg::edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // output holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ncd_dist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_dist_mem
// distance store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module ncd_dist_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [DW-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_a_i,
  input  logic [AW-1:0]        raddr_b_i,
  output logic signed [DW-1:0] rdata_a_o,
  output logic signed [DW-1:0] rdata_b_o
);

  logic signed [DW-1:0] mem_q [DEPTH];
  logic signed [DW-1:0] rdata_a_q;
  logic signed [DW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/ncd_relax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncd_relax
// edge relaxation test with saturation of the stored distance
// ----------------------------------------------------------------------------
module ncd_relax #(
  parameter int DW = 32
) (
  input  logic                                   edge_ok_i,
  input  logic signed [DW-1:0]                   dist_src_i,
  input  logic signed [DW-1:0]                   dist_dst_i,
  input  logic signed [ncd_pkg::WEIGHT_BITS-1:0] weight_i,
  output logic                                   relax_o,
  output logic signed [DW-1:0]                   dist_new_o
);

  localparam int SW = DW + 1;
  localparam logic signed [DW-1:0] LO = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] HI = {1'b0, {(DW-1){1'b1}}};

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] dst_ext;
  logic                 below;
  logic                 above;

  // exact sum, one bit wider than a distance
  assign sum     = SW'(dist_src_i) + SW'(weight_i);
  assign dst_ext = SW'(dist_dst_i);
  assign below   = weight_i[ncd_pkg::WEIGHT_BITS-1] && (sum < SW'(LO));
  assign above   = (weight_i > 0) && (sum > SW'(HI));

  assign relax_o    = edge_ok_i && (below || (!above && (dst_ext > sum)));
  assign dist_new_o = below ? LO : sum[DW-1:0];

endmodule

### hw/rtl/negative_cycle_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// negative_cycle_detector
// bellman-ford negative cycle detection over a streamed edge list
// ----------------------------------------------------------------------------
// Edges stream in at one per cycle while no run is in progress and are kept
// in the edge store; edges that name a vertex at or above node_count, or that
// arrive with the store full, are dropped and flagged. The request with
// last_edge set starts a run: the distance store is swept to the start value
// (n = min(node_count, MAX_NODES)), then n-1 relaxation passes and one check
// pass walk the stored edges. Each edge goes through the distance memory's
// read-modify-write loop (read both end points, then write the destination);
// the check pass stops at the first edge that still relaxes. One result then
// carries the verdict and the drop flag. New edges are taken while that
// result waits at the output, and node_count is taken whenever no run is in
// progress (cfg_ready_o is low from the last edge of a graph until its result
// is loaded).
// ----------------------------------------------------------------------------
module negative_cycle_detector #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 1024,
  parameter int DIST_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // edge requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ncd_pkg::in_req_t              in_req_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ncd_pkg::out_res_t             out_res_o,
  // node_count register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ncd_pkg::CFG_BITS-1:0]  cfg_data_i
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int CW  = ncd_pkg::CFG_BITS;

  // start distance, clipped to the largest distance if it does not fit
  localparam logic signed [DIST_BITS-1:0] START_VAL = (DIST_BITS >= 28) ?
      DIST_BITS'(ncd_pkg::START_DIST) : {1'b0, {(DIST_BITS-1){1'b1}}};

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_DREAD = 3'd2;
  localparam logic [2:0] ST_RELAX = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]     state_q, state_d;
  logic [CW-1:0]  node_count_q;
  logic [ECW-1:0] edge_count_q, edge_count_d;
  logic           error_q, error_d;
  logic [CW-1:0]  init_q, init_d;
  logic [CW-1:0]  pass_q, pass_d;
  logic [ECW-1:0] e_q, e_d;
  logic           found_q, found_d;
  logic           out_valid_q, out_valid_d;
  ncd_pkg::out_res_t out_res_q;

  // vertex count in use
  logic [CW-1:0]  n_use;
  logic [CW-1:0]  n_last;
  assign n_use  = (32'(node_count_q) < 32'(MAX_NODES)) ? node_count_q : CW'(MAX_NODES);
  assign n_last = n_use - CW'(1);

  // load side
  logic           in_accept;
  logic           in_ok;
  logic           store_full;
  logic           in_store;
  logic [ECW-1:0] count_after;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_ok       = ({1'b0, in_req_i.src_node} < n_use) &&
                       ({1'b0, in_req_i.dst_node} < n_use);
  assign store_full  = (edge_count_q == ECW'(MAX_EDGES));
  assign in_store    = in_ok && !store_full;
  assign count_after = edge_count_q + ECW'(in_store);

  // edge store
  ncd_pkg::edge_t edge_wr;
  ncd_pkg::edge_t edge_rd;
  logic           edge_re;
  logic [EAW-1:0] edge_raddr;
  logic [ECW-1:0] e_inc;

  assign edge_wr.src_node    = in_req_i.src_node;
  assign edge_wr.dst_node    = in_req_i.dst_node;
  assign edge_wr.edge_weight = in_req_i.edge_weight;
  assign e_inc = e_q + ECW'(1);

  ncd_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EAW)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (in_accept && in_store),
    .waddr_i (edge_count_q[EAW-1:0]),
    .wdata_i (edge_wr),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  // distance store and relaxation unit
  logic                        edge_ok;
  logic                        relax;
  logic signed [DIST_BITS-1:0] dist_src;
  logic signed [DIST_BITS-1:0] dist_dst;
  logic signed [DIST_BITS-1:0] dist_new;
  logic                        check_pass;
  logic                        last_in_pass;
  logic                        dist_we;
  logic [NAW-1:0]              dist_waddr;
  logic signed [DIST_BITS-1:0] dist_wdata;

  assign edge_ok = ({1'b0, edge_rd.src_node} < n_use) &&
                   ({1'b0, edge_rd.dst_node} < n_use);
  assign check_pass   = (pass_q == n_last);
  assign last_in_pass = (e_q == edge_count_q - ECW'(1));

  // sweep writes during init, relaxed distances in the update passes
  assign dist_we    = (state_q == ST_INIT) ||
                      ((state_q == ST_RELAX) && !check_pass && relax);
  assign dist_waddr = (state_q == ST_INIT) ? NAW'(init_q) : NAW'(edge_rd.dst_node);
  assign dist_wdata = (state_q == ST_INIT) ? START_VAL : dist_new;

  ncd_dist_mem #(
    .DEPTH (MAX_NODES),
    .AW    (NAW),
    .DW    (DIST_BITS)
  ) u_dist_mem (
    .clk_i     (clk_i),
    .we_i      (dist_we),
    .waddr_i   (dist_waddr),
    .wdata_i   (dist_wdata),
    .re_i      (state_q == ST_DREAD),
    .raddr_a_i (NAW'(edge_rd.src_node)),
    .raddr_b_i (NAW'(edge_rd.dst_node)),
    .rdata_a_o (dist_src),
    .rdata_b_o (dist_dst)
  );

  ncd_relax #(
    .DW (DIST_BITS)
  ) u_relax (
    .edge_ok_i  (edge_ok),
    .dist_src_i (dist_src),
    .dist_dst_i (dist_dst),
    .weight_i   (edge_rd.edge_weight),
    .relax_o    (relax),
    .dist_new_o (dist_new)
  );

  // result hand-off
  logic out_load;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d      = state_q;
    edge_count_d = edge_count_q;
    error_d      = error_q;
    init_d       = init_q;
    pass_d       = pass_q;
    e_d          = e_q;
    found_d      = found_q;
    edge_re      = 1'b0;
    edge_raddr   = e_inc[EAW-1:0];
    case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          edge_count_d = count_after;
          error_d      = error_q || !in_store;
          if (in_req_i.last_edge) begin
            found_d = 1'b0;
            init_d  = '0;
            pass_d  = '0;
            e_d     = '0;
            // nothing to walk: verdict is no cycle
            if ((n_use == '0) || (count_after == '0)) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_INIT: begin
        init_d = init_q + CW'(1);
        if (init_q == n_last) begin
          edge_re    = 1'b1;
          edge_raddr = '0;
          state_d    = ST_DREAD;
        end
      end
      ST_DREAD: begin
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        if (check_pass && relax) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else if (last_in_pass) begin
          if (check_pass) begin
            state_d = ST_DONE;
          end else begin
            pass_d     = pass_q + CW'(1);
            e_d        = '0;
            edge_re    = 1'b1;
            edge_raddr = '0;
            state_d    = ST_DREAD;
          end
        end else begin
          e_d     = e_inc;
          edge_re = 1'b1;
          state_d = ST_DREAD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          edge_count_d = '0;
          error_d      = 1'b0;
          state_d      = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      node_count_q <= CW'(1);
      edge_count_q <= '0;
      error_q      <= 1'b0;
      init_q       <= '0;
      pass_q       <= '0;
      e_q          <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_count_q <= edge_count_d;
      error_q      <= error_d;
      init_q       <= init_d;
      pass_q       <= pass_d;
      e_q          <= e_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        node_count_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q.negative_cycle <= found_q;
      out_res_q.input_error    <= error_q;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  // the vertex count stays fixed while a run walks the stores
  assign cfg_ready_o = (state_q == ST_LOAD);

  // distances change only in the sweep or in an update pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_we |-> ((state_q == ST_INIT) || ((state_q == ST_RELAX) && !check_pass)))
    else $error("distance write outside sweep or update pass");

  // the edge count never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_count_q) <= 32'(MAX_EDGES))
    else $error("edge count beyond store size");

  // a new result appears only out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || !out_stall_i) && out_valid_d && !out_valid_q |-> state_q == ST_DONE)
    else $error("result loaded outside done state");

  // handing off a result clears the graph for the next run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((edge_count_q == '0) && !error_q && (state_q == ST_LOAD)))
    else $error("graph state not cleared after result");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the negative cycle detector: streams edge lists,
// predicts each verdict with a bellman-ford tracker of its own and compares
// every result field by field, under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 1024;
  localparam int DIST_BITS = 32;
  localparam longint DIST_MAX = (longint'(1) <<< (DIST_BITS - 1)) - 1;
  localparam longint DIST_MIN = -DIST_MAX - 1;

  localparam int NODE_W   = ncd_pkg::NODE_BITS;
  localparam int WEIGHT_W = ncd_pkg::WEIGHT_BITS;
  localparam int CFG_W    = ncd_pkg::CFG_BITS;

  localparam int RANDOM_ITEMS   = 860;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 64;
  // longest legal silence is the saturation graph
  localparam int WATCHDOG_LIMIT = 500000;

  // idle mixes per phase of the random part, in percent
  localparam int unsigned SEND_IDLE_PCT[4]  = '{0, 58, 0, 13};
  localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 58, 13};

  // --------------------------------------------------------------------------
  // verdict tracker: mirrors the edge store, the drop flag and node_count,
  // runs the relaxation passes itself and queues the verdicts to come
  // --------------------------------------------------------------------------
  class ncd_verdict_tracker;
    int unsigned       node_count;
    ncd_pkg::edge_t    edge_q[$];
    bit                drop_seen;
    ncd_pkg::out_res_t verdict_q[$];
    int unsigned       mismatch_count;
    longint            dist_tab[MAX_NODES];

    function new();
      node_count     = 1;
      drop_seen      = 1'b0;
      mismatch_count = 0;
    endfunction

    function int unsigned nodes_in_use();
      return (node_count < MAX_NODES) ? node_count : MAX_NODES;
    endfunction

    // true if the edge still shortens its destination; the test uses the
    // exact sum, a stored value below the range sticks at the minimum
    function bit relax(ncd_pkg::edge_t ed, int unsigned n, bit update);
      longint w;
      longint dv;
      w = $signed(ed.edge_weight);
      if (ed.src_node >= n || ed.dst_node >= n) return 1'b0;
      dv = dist_tab[ed.src_node];
      if (w < 0 && dv < DIST_MIN - w) begin
        if (update) dist_tab[ed.dst_node] = DIST_MIN;
        return 1'b1;
      end
      if (w > 0 && dv > DIST_MAX - w) return 1'b0;
      if (dist_tab[ed.dst_node] > dv + w) begin
        if (update) dist_tab[ed.dst_node] = dv + w;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit has_negative_cycle(int unsigned n);
      longint      start;
      int unsigned i;
      int unsigned pass;
      start = (ncd_pkg::START_DIST > DIST_MAX) ? DIST_MAX : ncd_pkg::START_DIST;
      for (i = 0; i < n; i++) dist_tab[i] = start;
      for (pass = 0; pass + 1 < n; pass++) begin
        foreach (edge_q[k]) void'(relax(edge_q[k], n, 1'b1));
      end
      foreach (edge_q[k]) begin
        if (relax(edge_q[k], n, 1'b0)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_edge(ncd_pkg::in_req_t req);
      int unsigned       n;
      ncd_pkg::edge_t    ed;
      ncd_pkg::out_res_t verdict;
      n = nodes_in_use();
      if (req.src_node >= n || req.dst_node >= n || edge_q.size() >= MAX_EDGES) begin
        drop_seen = 1'b1;
      end else begin
        ed.src_node    = req.src_node;
        ed.dst_node    = req.dst_node;
        ed.edge_weight = req.edge_weight;
        edge_q = {edge_q, ed};
      end
      if (req.last_edge) begin
        verdict.negative_cycle = has_negative_cycle(n);
        verdict.input_error    = drop_seen;
        verdict_q = {verdict_q, verdict};
        edge_q.delete();
        drop_seen = 1'b0;
      end
    endfunction

    function void check_verdict(ncd_pkg::out_res_t got);
      ncd_pkg::out_res_t want;
      if (verdict_q.size() == 0) begin
        $error("result with none pending: negative_cycle %0d, input_error %0d",
               got.negative_cycle, got.input_error);
        mismatch_count++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.negative_cycle !== want.negative_cycle) begin
        $error("negative_cycle: expected %0d, actual %0d",
               want.negative_cycle, got.negative_cycle);
        mismatch_count++;
      end
      if (got.input_error !== want.input_error) begin
        $error("input_error: expected %0d, actual %0d", want.input_error, got.input_error);
        mismatch_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, block under test
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  ncd_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ncd_pkg::out_res_t out_res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i;

  ncd_verdict_tracker tracker = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  always #1 clk_i = ~clk_i;

  negative_cycle_detector #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .DIST_BITS (DIST_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // receiver back-pressure, redrawn every cycle from the current mix
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor and watchdog: everything is sampled at the edge, before the
  // block's own updates land, so an accepted request is exactly what the
  // block saw; the watchdog restarts on any accepted request, result or write
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_edge(in_req_i);
      if (out_valid_o && !out_stall_i) tracker.check_verdict(out_res_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one edge request; an optional gap goes in front, valid then stays high
  // until the edge is taken so the next request can follow back to back
  task automatic send_edge(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                           logic [WEIGHT_W-1:0] wt, logic last);
    ncd_pkg::in_req_t req;
    req.src_node    = src;
    req.dst_node    = dst;
    req.edge_weight = wt;
    req.last_edge   = last;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender holds off until every pending verdict is out; the first edge
  // lets the monitor log the request just taken before the queue is read
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.node_count = value;
  endtask

  // mostly small weights so that both verdicts are common, some full range
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int wv;
    if ($urandom_range(99) < 70) begin
      wv = int'($urandom_range(30)) - 10;
      return wv[WEIGHT_W-1:0];
    end
    return WEIGHT_W'($urandom_range(16'hFFFF));
  endfunction

  // mostly a handful of vertices, now and then zero, the top of the range
  // or beyond the store
  function automatic logic [CFG_W-1:0] pick_node_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) return CFG_W'($urandom_range(1, 12));
    if (r < 83) return '0;
    if (r < 88) return '1;
    if (r < 93) return CFG_W'(MAX_NODES);
    return CFG_W'($urandom_range(13, 2046));
  endfunction

  // one graph: well-formed edges plus a few with random, usually bad, ends;
  // large vertex counts keep the list short since every pass walks them all
  task automatic send_random_graph(output int unsigned sent);
    int unsigned        n;
    int unsigned        count;
    int unsigned        k;
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    n     = tracker.nodes_in_use();
    count = (n > 64) ? $urandom_range(1, 3) : $urandom_range(1, 12);
    for (k = 0; k < count; k++) begin
      if (n == 0 || $urandom_range(99) < 12) begin
        src = NODE_W'($urandom_range(1023));
        dst = NODE_W'($urandom_range(1023));
      end else begin
        src = NODE_W'($urandom_range(n - 1));
        dst = NODE_W'($urandom_range(n - 1));
      end
      send_edge(src, dst, pick_weight(), k == count - 1);
    end
    sent = count;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned done;
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    int unsigned k;
    int unsigned loop_node;
    int          wv;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // reset vertex count of one: zero self loop, then a negative one
    send_edge(10'd0, 10'd0, 16'h0000, 1'b1);
    send_edge(10'd0, 10'd0, 16'hFFFF, 1'b1);

    // no vertices at all: every edge dropped, no pass runs
    write_node_count('0);
    send_edge(10'd0, 10'd0, 16'h0005, 1'b1);

    // count beyond the store, extreme indices and weights, cycle sum of -1
    write_node_count('1);
    send_edge(10'd1023, 10'd0, 16'h8000, 1'b0);
    send_edge(10'd0, 10'd1023, 16'h7FFF, 1'b1);

    // empty graph: the only edge is dropped
    write_node_count(11'd4);
    send_edge(10'd1023, 10'd2, 16'h0003, 1'b1);

    // a negative edge but a zero-weight cycle
    send_edge(10'd0, 10'd1, 16'hFFFB, 1'b0);
    send_edge(10'd1, 10'd2, 16'h0003, 1'b0);
    send_edge(10'd2, 10'd0, 16'h0002, 1'b1);

    // count lowered mid-load: the negative loop on 5 and 6 must be skipped
    write_node_count(11'd8);
    send_edge(10'd5, 10'd6, 16'hFFFD, 1'b0);
    send_edge(10'd6, 10'd5, 16'h0001, 1'b0);
    send_edge(10'd0, 10'd1, 16'h0002, 1'b0);
    write_node_count(11'd4);
    send_edge(10'd1, 10'd0, 16'h0001, 1'b1);

    // full vertex range, top bits of both indices set
    write_node_count(CFG_W'(MAX_NODES));
    send_edge(10'd1023, 10'd512, 16'h0064, 1'b0);
    send_edge(10'd512, 10'd1023, 16'hFF9B, 1'b1);

    // ---- random part ----
    done = 0;
    while (done < RANDOM_ITEMS) begin
      phase          = done * 4 / RANDOM_ITEMS;
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      if ($urandom_range(2) == 0) write_node_count(pick_node_count());
      send_random_graph(sent);
      done += sent;
    end

    // saturation: stacked strongly negative self loops push one distance
    // below the signed range over the 1023 passes
    write_node_count(CFG_W'(MAX_NODES));
    count     = $urandom_range(72, 76);
    loop_node = $urandom_range(1023);
    for (k = 0; k < count; k++) begin
      wv = -int'($urandom_range(31000, 32768));
      send_edge(NODE_W'(loop_node), NODE_W'(loop_node), wv[WEIGHT_W-1:0],
                k == count - 1);
    end

    // ---- wrap-up ----
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### negative_cycle_detector.f
hw/rtl/ncd_pkg.sv
hw/rtl/ncd_edge_mem.sv
hw/rtl/ncd_dist_mem.sv
hw/rtl/ncd_relax.sv
hw/rtl/negative_cycle_detector.sv
tb/testbench.sv
